// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file psws_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== hw/rtl/psws_pkg.sv =====
`timescale 1ns / 1ps

package psws_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned FRAME_LEN = 24;
    localparam int unsigned CNT_W   = 5;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [FRAME_LEN-1:0] frame_bits_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // A built frame offered to the shifter; the most significant bit goes out first.
    typedef struct packed {
        logic        valid;
        frame_bits_t bits;
    } frame_t;

endpackage

// ===== hw/rtl/psws_frame_builder.sv =====
`timescale 1ns / 1ps

module psws_frame_builder
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psws_pkg::word_t     data_word,
    output psws_pkg::frame_t    frame,
    input  logic                frame_take
);

    logic            word_valid_reg;
    psws_pkg::word_t word_reg;
    psws_pkg::word_t adj_word;

    assign in_ready = !word_valid_reg || frame_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            word_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= data_word;
        end
    end

    // Bit 15 is replaced so that the word has an even number of ones.
    assign adj_word = {^word_reg[14:0], word_reg[14:0]};

    assign frame.valid = word_valid_reg;
    assign frame.bits  = {1'b1, 1'b0,
                          adj_word[15:12], ~adj_word[12],
                          adj_word[11:8],  ~adj_word[8],
                          adj_word[7:4],   ~adj_word[4],
                          adj_word[3:0],   ~adj_word[0],
                          1'b0, 1'b0};

endmodule

// ===== hw/rtl/psws_shifter.sv =====
`timescale 1ns / 1ps

module psws_shifter
(
    input  logic             clk,
    input  logic             rst_n,
    input  psws_pkg::frame_t frame,
    output logic             frame_take,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             line_level,
    output logic             frame_end
);

    psws_pkg::frame_bits_t shift_reg;
    psws_pkg::frame_bits_t shift_next;
    psws_pkg::cnt_t        cnt_reg;
    psws_pkg::cnt_t        cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  level_reg;
    logic                  level_next;
    logic                  end_reg;
    logic                  end_next;
    logic                  advance;

    assign advance    = !out_valid_reg || out_ready;
    assign frame_take = advance && (cnt_reg == '0) && frame.valid;

    always_comb
    begin
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        end_next       = end_reg;
        if (advance)
        begin
            priority if (cnt_reg != '0)
            begin
                level_next     = shift_reg[psws_pkg::FRAME_LEN-1];
                shift_next     = {shift_reg[psws_pkg::FRAME_LEN-2:0], 1'b0};
                cnt_next       = psws_pkg::cnt_t'(cnt_reg - 1'b1);
                end_next       = (cnt_reg == psws_pkg::cnt_t'(1));
                out_valid_next = 1'b1;
            end
            else if (frame.valid)
            begin
                level_next     = frame.bits[psws_pkg::FRAME_LEN-1];
                shift_next     = {frame.bits[psws_pkg::FRAME_LEN-2:0], 1'b0};
                cnt_next       = psws_pkg::cnt_t'(psws_pkg::FRAME_LEN - 1);
                end_next       = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        level_reg <= level_next;
        end_reg   <= end_next;
    end

    assign out_valid  = out_valid_reg;
    assign line_level = level_reg;
    assign frame_end  = end_reg;

endmodule

// ===== hw/rtl/parity_stuffed_word_serializer.sv =====
`timescale 1ns / 1ps
// A word is registered, then the shifter loads its frame and shows its first level.
// Output: one level per cycle while out_ready is high; a word gives 24 levels,
// and frames follow without gaps; the 24-bit shift register sets the frame length.
// A word is held in the input register while the previous frame is shifted out.
// Reset (rst_n low, asynchronous) empties the input register and the shifter.

module parity_stuffed_word_serializer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        line_level,
    output logic        frame_end
);

    psws_pkg::frame_t frame;
    logic             frame_take;

    psws_frame_builder u_builder
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .frame      (frame),
        .frame_take (frame_take)
    );

    psws_shifter u_shifter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .frame_take (frame_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_level (line_level),
        .frame_end  (frame_end)
    );

endmodule

// ===== hw/rtl/psws_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psws_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] data_word,
    input logic        out_valid,
    input logic        out_ready,
    input logic        line_level,
    input logic        frame_end
);

    localparam psws_pkg::cnt_t LAST_POS = psws_pkg::cnt_t'(psws_pkg::FRAME_LEN - 1);

    psws_pkg::cnt_t pos_reg;
    logic           prev_level_reg;
    logic           out_fire;
    logic           stuff_pos;
    logic           low_pos;

    assign out_fire  = out_valid && out_ready;
    assign stuff_pos = (pos_reg == psws_pkg::cnt_t'(6)) || (pos_reg == psws_pkg::cnt_t'(11)) ||
                       (pos_reg == psws_pkg::cnt_t'(16)) || (pos_reg == psws_pkg::cnt_t'(21));
    assign low_pos   = (pos_reg == psws_pkg::cnt_t'(1)) ||
                       (pos_reg == psws_pkg::cnt_t'(22)) || (pos_reg == LAST_POS);

    // Position of the next level within its frame, counted over delivered items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            prev_level_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            pos_reg        <= (pos_reg == LAST_POS) ? '0 : psws_pkg::cnt_t'(pos_reg + 1'b1);
            prev_level_reg <= line_level;
        end
    end

    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(data_word))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(line_level) && $stable(frame_end))
    `ASSERT_SAME(a_frame_end_pos, clk, rst_n, out_valid, frame_end == (pos_reg == LAST_POS))
    `ASSERT_SAME(a_frame_levels, clk, rst_n, out_valid, (pos_reg == '0) ? line_level : (!low_pos || !line_level))
    `ASSERT_SAME(a_stuff_inverts, clk, rst_n, out_valid && stuff_pos, line_level != prev_level_reg)

endmodule

bind parity_stuffed_word_serializer psws_checker u_psws_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_level (line_level),
    .frame_end  (frame_end)
);
